>>> hw/rtl/skew_product_escape_time_macros.svh
// assertion macros for the skew-product escape-time block
// used by the port checker; expects clk and rst_n in scope
`ifndef SKEW_PRODUCT_ESCAPE_TIME_MACROS_SVH
`define SKEW_PRODUCT_ESCAPE_TIME_MACROS_SVH

// same-cycle implication
`define SPET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/spet_pkg.sv
// shared types and constants of the skew-product escape-time block
// no dependencies; used by all rtl modules by scoped names
`default_nettype none

package spet_pkg;

    localparam int IN_W          = 32;   // config and input word width
    localparam int LIMIT_W       = 16;   // iteration limit width
    localparam int CODE_W        = 19;   // color code width
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 28;

    // internal Q16.40 format
    localparam int INT_W    = 56;
    localparam int INT_FRAC = 40;
    localparam int HALF_W   = INT_W / 2;
    localparam int PROD_W   = 2 * INT_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int SCL_W    = ACC_W - INT_FRAC;
    localparam int U_W      = INT_W + 3;

    typedef logic signed [INT_W-1:0]  fix_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [CODE_W-1:0] code_t;
    typedef logic [LIMIT_W-1:0]       iter_t;

    localparam fix_t SAT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam fix_t SAT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    // escape radius squared (10000) in the product scale 2^80
    localparam acc_t NORM_LIMIT = acc_t'(10000) <<< (2 * INT_FRAC);

    localparam code_t CODE_NONE    = '1;
    localparam code_t CODE_OFFSET  = code_t'(41);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_START_RE    = 3'd0,
        REG_X_START_IM    = 3'd1,
        REG_SHIFT_RE      = 3'd2,
        REG_SHIFT_IM      = 3'd3,
        REG_ITER_LIMIT    = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OPND_YR,
        OPND_YI,
        OPND_UR,
        OPND_UI,
        OPND_XR,
        OPND_XI
    } opnd_t;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_NORM,
        WB_YR,
        WB_YI,
        WB_XR,
        WB_XI
    } wb_t;

    typedef struct packed {
        logic    load_item;
        logic    calc_u;
        logic    issue;
        opnd_t   op_a;
        opnd_t   op_b;
        acc_op_t acc_op;
        wb_t     wb;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic in_radius;
        logic ysat;
        logic yim_pos;
    } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/spet_dp.sv
// datapath: y, x, b, u registers and a pipelined 56x56 multiply-accumulate
// uses spet_pkg; driven by spet_ctrl through cmd_t, reports through stat_t
`default_nettype none

module spet_dp #(
    parameter int FRAC_BITS = spet_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [spet_pkg::IN_W-1:0]  point_re,
    input  wire logic [spet_pkg::IN_W-1:0]  point_im,
    input  wire logic [spet_pkg::IN_W-1:0]  x_start_re,
    input  wire logic [spet_pkg::IN_W-1:0]  x_start_im,
    input  wire logic [spet_pkg::IN_W-1:0]  shift_re,
    input  wire logic [spet_pkg::IN_W-1:0]  shift_im,
    input  wire spet_pkg::cmd_t             cmd,
    output spet_pkg::stat_t                 stat
);

    localparam int SH   = spet_pkg::INT_FRAC - FRAC_BITS;
    localparam int HW   = spet_pkg::HALF_W;
    localparam int IW   = spet_pkg::INT_W;
    localparam int PPW  = 2 * HW;
    localparam int PPW1 = 2 * HW + 1;

    function automatic spet_pkg::fix_t widen(input logic [spet_pkg::IN_W-1:0] v);
        logic signed [spet_pkg::IN_W-1:0] s;
        spet_pkg::fix_t t;
        s = signed'(v);
        t = spet_pkg::fix_t'(s);
        return t <<< SH;
    endfunction

    spet_pkg::fix_t yr_reg, yi_reg, xr_reg, xi_reg, br_reg, bi_reg, ur_reg, ui_reg;
    logic           ysat_reg, inside_reg;

    // pipeline stage 1: partial products
    logic                   v1_reg;
    spet_pkg::acc_op_t      s1_acc_reg;
    spet_pkg::wb_t          s1_wb_reg;
    logic [2*HW-1:0]        ll_reg;
    logic signed [2*HW:0]   lh_reg, hl_reg;
    logic signed [2*HW-1:0] hh_reg;

    // pipeline stage 2: full product
    logic                               v2_reg;
    spet_pkg::acc_op_t                  s2_acc_reg;
    spet_pkg::wb_t                      s2_wb_reg;
    logic signed [spet_pkg::PROD_W-1:0] prod_reg;

    // pipeline stage 3: accumulator, write-back pending
    logic           v3_reg;
    spet_pkg::wb_t  s3_wb_reg;
    spet_pkg::acc_t acc_reg;

    spet_pkg::fix_t         opa, opb;
    logic [HW-1:0]          a_lo, b_lo;
    logic signed [HW-1:0]   a_hi, b_hi;
    logic [2*HW-1:0]        ll_next;
    logic signed [2*HW:0]   lh_next, hl_next;
    logic signed [2*HW-1:0] hh_next;

    logic signed [spet_pkg::PROD_W-1:0] t_hh, t_mid, t_ll, prod_next;
    spet_pkg::acc_t                     acc_base, prod_ext, acc_next;

    logic signed [spet_pkg::U_W-1:0] t_y, t_x, t_b, ur_w, ui_w;
    spet_pkg::fix_t                  ur_c, ui_c;
    logic                            usat;

    logic signed [spet_pkg::SCL_W-1:0] scl;
    spet_pkg::fix_t                    wb_val;
    logic                              wb_sat;

    function automatic spet_pkg::fix_t pick(input spet_pkg::opnd_t s,
                                            input spet_pkg::fix_t yr,
                                            input spet_pkg::fix_t yi,
                                            input spet_pkg::fix_t ur,
                                            input spet_pkg::fix_t ui,
                                            input spet_pkg::fix_t xr,
                                            input spet_pkg::fix_t xi);
        spet_pkg::fix_t r;
        case (s)
            spet_pkg::OPND_YR: r = yr;
            spet_pkg::OPND_YI: r = yi;
            spet_pkg::OPND_UR: r = ur;
            spet_pkg::OPND_UI: r = ui;
            spet_pkg::OPND_XR: r = xr;
            spet_pkg::OPND_XI: r = xi;
            default:           r = '0;
        endcase
        return r;
    endfunction

    // clamp a u component into the internal range
    function automatic spet_pkg::fix_t clamp_u(input logic signed [spet_pkg::U_W-1:0] v);
        spet_pkg::fix_t r;
        if (v > spet_pkg::SAT_MAX)
            r = spet_pkg::SAT_MAX;
        else if (v < spet_pkg::SAT_MIN)
            r = spet_pkg::SAT_MIN;
        else
            r = v[IW-1:0];
        return r;
    endfunction

    // u = y + 2(b - x)
    always_comb
    begin
        t_y  = spet_pkg::U_W'(yr_reg);
        t_x  = spet_pkg::U_W'(xr_reg);
        t_b  = spet_pkg::U_W'(br_reg);
        ur_w = t_y + ((t_b - t_x) <<< 1);
        t_y  = spet_pkg::U_W'(yi_reg);
        t_x  = spet_pkg::U_W'(xi_reg);
        t_b  = spet_pkg::U_W'(bi_reg);
        ui_w = t_y + ((t_b - t_x) <<< 1);
        ur_c = clamp_u(ur_w);
        ui_c = clamp_u(ui_w);
        usat = (ur_w > spet_pkg::SAT_MAX) || (ur_w < spet_pkg::SAT_MIN) ||
               (ui_w > spet_pkg::SAT_MAX) || (ui_w < spet_pkg::SAT_MIN);
    end

    // partial products of the selected operands
    always_comb
    begin
        opa     = pick(cmd.op_a, yr_reg, yi_reg, ur_reg, ui_reg, xr_reg, xi_reg);
        opb     = pick(cmd.op_b, yr_reg, yi_reg, ur_reg, ui_reg, xr_reg, xi_reg);
        a_lo    = opa[HW-1:0];
        b_lo    = opb[HW-1:0];
        a_hi    = opa[IW-1:HW];
        b_hi    = opb[IW-1:HW];
        ll_next = PPW'(a_lo) * PPW'(b_lo);
        lh_next = PPW1'(signed'({1'b0, a_lo})) * PPW1'(b_hi);
        hl_next = PPW1'(a_hi) * PPW1'(signed'({1'b0, b_lo}));
        hh_next = PPW'(a_hi) * PPW'(b_hi);
    end

    always_comb
    begin
        t_hh      = spet_pkg::PROD_W'(hh_reg);
        t_mid     = spet_pkg::PROD_W'(lh_reg) + spet_pkg::PROD_W'(hl_reg);
        t_ll      = signed'({{(spet_pkg::PROD_W - 2*HW){1'b0}}, ll_reg});
        prod_next = (t_hh <<< (2*HW)) + (t_mid <<< HW) + t_ll;
    end

    always_comb
    begin
        prod_ext = spet_pkg::acc_t'(prod_reg);
        acc_base = (s2_acc_reg == spet_pkg::ACC_LOAD) ? '0 : acc_reg;
        if (s2_acc_reg == spet_pkg::ACC_SUB)
            acc_next = acc_base - prod_ext;
        else
            acc_next = acc_base + prod_ext;
    end

    // floor shift by the fraction width, then clamp
    always_comb
    begin
        scl    = acc_reg[spet_pkg::ACC_W-1:spet_pkg::INT_FRAC];
        wb_sat = (scl > spet_pkg::SAT_MAX) || (scl < spet_pkg::SAT_MIN);
        if (scl > spet_pkg::SAT_MAX)
            wb_val = spet_pkg::SAT_MAX;
        else if (scl < spet_pkg::SAT_MIN)
            wb_val = spet_pkg::SAT_MIN;
        else
            wb_val = scl[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            ysat_reg   <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.load_item)
                ysat_reg <= 1'b0;
            else if (cmd.calc_u && usat)
                ysat_reg <= 1'b1;
            else if (v3_reg && wb_sat &&
                     (s3_wb_reg == spet_pkg::WB_YR || s3_wb_reg == spet_pkg::WB_YI))
                ysat_reg <= 1'b1;
            if (v3_reg && s3_wb_reg == spet_pkg::WB_NORM)
                inside_reg <= (acc_reg < spet_pkg::NORM_LIMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_acc_reg <= cmd.acc_op;
        s1_wb_reg  <= cmd.issue ? cmd.wb : spet_pkg::WB_NONE;
        ll_reg     <= ll_next;
        lh_reg     <= lh_next;
        hl_reg     <= hl_next;
        hh_reg     <= hh_next;
        s2_acc_reg <= s1_acc_reg;
        s2_wb_reg  <= v1_reg ? s1_wb_reg : spet_pkg::WB_NONE;
        prod_reg   <= prod_next;
        s3_wb_reg  <= v2_reg ? s2_wb_reg : spet_pkg::WB_NONE;
        if (v2_reg)
            acc_reg <= acc_next;
        if (cmd.calc_u)
        begin
            ur_reg <= ur_c;
            ui_reg <= ui_c;
        end
        if (cmd.load_item)
        begin
            yr_reg <= widen(point_re);
            yi_reg <= widen(point_im);
            xr_reg <= widen(x_start_re);
            xi_reg <= widen(x_start_im);
            br_reg <= widen(shift_re);
            bi_reg <= widen(shift_im);
        end
        else if (v3_reg)
        begin
            case (s3_wb_reg)
                spet_pkg::WB_YR: yr_reg <= wb_val;
                spet_pkg::WB_YI: yi_reg <= wb_val;
                spet_pkg::WB_XR: xr_reg <= wb_val;
                spet_pkg::WB_XI: xi_reg <= wb_val;
                default: ;
            endcase
        end
    end

    assign stat.busy      = v1_reg | v2_reg | v3_reg;
    assign stat.in_radius = inside_reg;
    assign stat.ysat      = ysat_reg;
    assign stat.yim_pos   = (yi_reg > 0);

endmodule

`default_nettype wire

>>> hw/rtl/spet_ctrl.sv
// controller: sequences the product pipe, counts iterations, holds the result item
// uses spet_pkg; commands spet_dp through cmd_t and reads stat_t
`default_nettype none

module spet_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output spet_pkg::code_t                    code,
    output logic                               escaped,
    input  wire logic [spet_pkg::LIMIT_W-1:0]  iteration_limit,
    output spet_pkg::cmd_t                     cmd,
    input  wire spet_pkg::stat_t               stat
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_NORM  = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_UCALC = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    localparam logic [2:0] MUL_LAST  = 3'd7;
    localparam logic [2:0] NORM_LAST = 3'd1;

    state_t          state_reg, state_next;
    logic [2:0]      op_cnt_reg, op_cnt_next;
    spet_pkg::iter_t iter_reg, iter_next;
    logic            m_tvalid_reg, m_tvalid_next;
    spet_pkg::code_t code_reg;
    logic            esc_reg;

    logic            go_on, res_load, esc_w;
    spet_pkg::code_t code_w, dbl;

    function automatic spet_pkg::cmd_t mk(input spet_pkg::opnd_t a,
                                          input spet_pkg::opnd_t b,
                                          input spet_pkg::acc_op_t op,
                                          input spet_pkg::wb_t wb);
        spet_pkg::cmd_t c;
        c.load_item = 1'b0;
        c.calc_u    = 1'b0;
        c.issue     = 1'b1;
        c.op_a      = a;
        c.op_b      = b;
        c.acc_op    = op;
        c.wb        = wb;
        return c;
    endfunction

    // new y = u*y, then x = x*x
    function automatic spet_pkg::cmd_t mul_op(input logic [2:0] idx);
        spet_pkg::cmd_t c;
        case (idx)
            3'd0: c = mk(spet_pkg::OPND_UR, spet_pkg::OPND_YR, spet_pkg::ACC_LOAD,
                         spet_pkg::WB_NONE);
            3'd1: c = mk(spet_pkg::OPND_UI, spet_pkg::OPND_YI, spet_pkg::ACC_SUB,
                         spet_pkg::WB_YR);
            3'd2: c = mk(spet_pkg::OPND_UR, spet_pkg::OPND_YI, spet_pkg::ACC_LOAD,
                         spet_pkg::WB_NONE);
            3'd3: c = mk(spet_pkg::OPND_UI, spet_pkg::OPND_YR, spet_pkg::ACC_ADD,
                         spet_pkg::WB_YI);
            3'd4: c = mk(spet_pkg::OPND_XR, spet_pkg::OPND_XR, spet_pkg::ACC_LOAD,
                         spet_pkg::WB_NONE);
            3'd5: c = mk(spet_pkg::OPND_XI, spet_pkg::OPND_XI, spet_pkg::ACC_SUB,
                         spet_pkg::WB_XR);
            3'd6: c = mk(spet_pkg::OPND_XR, spet_pkg::OPND_XI, spet_pkg::ACC_LOAD,
                         spet_pkg::WB_NONE);
            default: c = mk(spet_pkg::OPND_XR, spet_pkg::OPND_XI, spet_pkg::ACC_ADD,
                            spet_pkg::WB_XI);
        endcase
        return c;
    endfunction

    always_comb
    begin
        go_on  = (iter_reg < iteration_limit) && !stat.ysat && stat.in_radius;
        esc_w  = (iter_reg < iteration_limit);
        dbl    = spet_pkg::code_t'({iter_reg, 1'b0});
        if (!esc_w)
            code_w = spet_pkg::CODE_NONE;
        else if (stat.yim_pos)
            code_w = dbl;
        else
            code_w = dbl + spet_pkg::CODE_OFFSET;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_cnt_next   = op_cnt_reg;
        iter_next     = iter_reg;
        res_load      = 1'b0;
        cmd           = mk(spet_pkg::OPND_YR, spet_pkg::OPND_YR, spet_pkg::ACC_LOAD,
                           spet_pkg::WB_NONE);
        cmd.issue     = 1'b0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    iter_next     = '0;
                    op_cnt_next   = '0;
                    state_next    = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (op_cnt_reg == '0)
                    cmd = mk(spet_pkg::OPND_YR, spet_pkg::OPND_YR, spet_pkg::ACC_LOAD,
                             spet_pkg::WB_NONE);
                else
                    cmd = mk(spet_pkg::OPND_YI, spet_pkg::OPND_YI, spet_pkg::ACC_ADD,
                             spet_pkg::WB_NORM);
                op_cnt_next = op_cnt_reg + 3'd1;
                if (op_cnt_reg == NORM_LAST)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                // all write-backs must land before the loop test
                if (!stat.busy)
                    state_next = go_on ? ST_UCALC : ST_DONE;
            end
            ST_UCALC:
            begin
                cmd.calc_u  = 1'b1;
                iter_next   = iter_reg + spet_pkg::iter_t'(1);
                op_cnt_next = '0;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd         = mul_op(op_cnt_reg);
                op_cnt_next = op_cnt_reg + 3'd1;
                if (op_cnt_reg == MUL_LAST)
                begin
                    op_cnt_next = '0;
                    state_next  = ST_NORM;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_cnt_reg   <= '0;
            iter_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_cnt_reg   <= op_cnt_next;
            iter_reg     <= iter_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            code_reg <= code_w;
            esc_reg  <= esc_w;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign code     = code_reg;
    assign escaped  = esc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/skew_product_escape_time.sv
// an item runs n iterations; each iteration issues ten 56x56 products into one shared
// multiply-accumulate pipe and waits for its write-back before the escape test;
// one item is worked at a time, so a new input item is not taken before the previous
// one has finished its iterations, and later still under output stalls
// an input item is taken while the previous result item still waits in its register
// rst_n is asynchronous, active low; clears control state, loads x0 = b = 1.0, limit 500
`default_nettype none

module skew_product_escape_time #(
    parameter int FRAC_BITS = spet_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [spet_pkg::IN_TDATA_W-1:0]    s_tdata,   // point_re, point_im
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [spet_pkg::OUT_TDATA_W-1:0]        m_tdata,   // color_code, zero pad
    output logic                                    m_tuser,   // escaped
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [spet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [spet_pkg::IN_W-1:0]          cfg_data
);

    localparam logic [spet_pkg::IN_W-1:0] ONE_FIX = 32'd1 << FRAC_BITS;
    localparam int PAD_W = spet_pkg::OUT_TDATA_W - spet_pkg::CODE_W;

    logic [spet_pkg::IN_W-1:0]    x_start_re_reg, x_start_im_reg, shift_re_reg, shift_im_reg;
    logic [spet_pkg::LIMIT_W-1:0] iteration_limit_reg;

    spet_pkg::cmd_t  cmd;
    spet_pkg::stat_t stat;
    spet_pkg::code_t code;
    logic            escaped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_re_reg      <= ONE_FIX;
            x_start_im_reg      <= '0;
            shift_re_reg        <= ONE_FIX;
            shift_im_reg        <= '0;
            iteration_limit_reg <= spet_pkg::LIMIT_W'(500);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spet_pkg::REG_X_START_RE: x_start_re_reg <= cfg_data;
                spet_pkg::REG_X_START_IM: x_start_im_reg <= cfg_data;
                spet_pkg::REG_SHIFT_RE:   shift_re_reg   <= cfg_data;
                spet_pkg::REG_SHIFT_IM:   shift_im_reg   <= cfg_data;
                spet_pkg::REG_ITER_LIMIT:
                    iteration_limit_reg <= cfg_data[spet_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    spet_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .code            (code),
        .escaped         (escaped),
        .iteration_limit (iteration_limit_reg),
        .cmd             (cmd),
        .stat            (stat)
    );

    spet_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .point_re   (s_tdata[spet_pkg::IN_W-1:0]),
        .point_im   (s_tdata[2*spet_pkg::IN_W-1:spet_pkg::IN_W]),
        .x_start_re (x_start_re_reg),
        .x_start_im (x_start_im_reg),
        .shift_re   (shift_re_reg),
        .shift_im   (shift_im_reg),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign m_tdata = {{PAD_W{1'b0}}, code};
    assign m_tuser = escaped;

endmodule

`default_nettype wire

>>> hw/rtl/spet_check.sv
// port checker for skew_product_escape_time, bound to the top level
// uses spet_pkg and the macros in skew_product_escape_time_macros.svh
`default_nettype none
`include "skew_product_escape_time_macros.svh"

module spet_check (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [spet_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic                                m_tuser
);

    // a result item held back keeps its value
    `SPET_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

    // no escape means the all-ones code
    `SPET_ASSERT_NOW(a_no_escape_code, m_tvalid && !m_tuser,
        m_tdata[spet_pkg::CODE_W-1:0] == spet_pkg::CODE_NONE, "non-escape code is not -1")

    // an escape code is never negative and the pad stays clear
    `SPET_ASSERT_NOW(a_escape_code, m_tvalid && m_tuser,
        !m_tdata[spet_pkg::CODE_W-1] && m_tdata[spet_pkg::OUT_TDATA_W-1:spet_pkg::CODE_W] == '0,
        "bad escape code")

    // one item at a time: input closes right after an item is taken
    `SPET_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready,
        "second item taken while busy")

endmodule

bind skew_product_escape_time spet_check u_spet_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> sim/tb_skew_product_escape_time.sv
`timescale 1ns / 1ps
// self-checking bench for skew_product_escape_time: streams complex points,
// predicts each color code with a bit-exact Q16.40 orbit model and compares
// depends on spet_pkg and the skew_product_escape_time rtl

module tb_skew_product_escape_time;

    localparam int IDX_W       = spet_pkg::CFG_IDX_W;
    localparam int CODE_W      = spet_pkg::CODE_W;
    localparam int FIX_W       = 56;
    localparam int FIX_FRAC    = 40;
    localparam int Q_FRAC      = 28;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASE_ITEMS = 75;
    localparam int DRAIN_AT    = 40;

    typedef logic signed [FIX_W-1:0] q16_t;
    typedef logic signed [127:0]     wide_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              escaped;
    } color_t;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        bit          drain;
    } point_t;

    localparam wide_t FIX_HI      = (wide_t'(1) <<< (FIX_W - 1)) - 1;
    localparam wide_t FIX_LO      = -(wide_t'(1) <<< (FIX_W - 1));
    localparam wide_t ESCAPE_NORM = wide_t'(10000) <<< (2 * FIX_FRAC);

    localparam logic [CODE_W-1:0] NO_ESCAPE_CODE = '1;
    localparam int                NONPOS_OFFSET  = 41;

    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ZERO = 32'h0000_0000;
    localparam logic [31:0] Q_ONE  = 32'h1000_0000;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [spet_pkg::IN_TDATA_W-1:0]    s_tdata = '0;   // point_re, point_im
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [spet_pkg::OUT_TDATA_W-1:0]   m_tdata;        // color_code, zero pad
    logic                               m_tuser;        // escaped
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [IDX_W-1:0]                   cfg_index = '0;
    logic [31:0]                        cfg_data = '0;

    // register shadow, reset values of the block
    logic [31:0] x0_re = Q_ONE;
    logic [31:0] x0_im = Q_ZERO;
    logic [31:0] b_re = Q_ONE;
    logic [31:0] b_im = Q_ZERO;
    logic [15:0] iter_limit = 16'd500;

    point_t pending_points[$];
    color_t due_colors[$];
    bit     point_taken = 1'b0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     errors = 0;
    int     cycles = 0;

    int          send_idle_tab[4] = '{0, 63, 0, 38};
    int          recv_stall_tab[4] = '{0, 0, 63, 38};
    logic [15:0] phase_limit[8] = '{16'd1, 16'd7, 16'd24, 16'd60, 16'd0, 16'hFFFF,
                                    16'd13, 16'd100};

    skew_product_escape_time uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic q16_t to_q16(input logic [31:0] v);
        q16_t w;
        w = {{(FIX_W - 32){v[31]}}, v};
        return w <<< (FIX_FRAC - Q_FRAC);
    endfunction

    function automatic bit out_of_range(input wide_t v);
        return (v > FIX_HI) || (v < FIX_LO);
    endfunction

    function automatic q16_t clamp_q16(input wide_t v);
        if (v > FIX_HI)
            v = FIX_HI;
        else if (v < FIX_LO)
            v = FIX_LO;
        return v[FIX_W-1:0];
    endfunction

    function automatic wide_t prod(input q16_t a, input q16_t b);
        return wide_t'(a) * wide_t'(b);
    endfunction

    // runs the orbit of one point under the shadowed registers
    function automatic color_t escape_color(input logic [31:0] pre, input logic [31:0] pim);
        q16_t        yr, yi, xr, xi, br, bi, ur, ui;
        wide_t       ur_w, ui_w, re_w, im_w;
        bit          ysat;
        int unsigned n;
        color_t      c;
        yr = to_q16(pre);
        yi = to_q16(pim);
        xr = to_q16(x0_re);
        xi = to_q16(x0_im);
        br = to_q16(b_re);
        bi = to_q16(b_im);
        ysat = 1'b0;
        n = 0;
        while (n < iter_limit && !ysat && (prod(yr, yr) + prod(yi, yi)) < ESCAPE_NORM)
        begin
            ur_w = wide_t'(yr) + ((wide_t'(br) - wide_t'(xr)) <<< 1);
            ui_w = wide_t'(yi) + ((wide_t'(bi) - wide_t'(xi)) <<< 1);
            ysat = ysat | out_of_range(ur_w) | out_of_range(ui_w);
            ur = clamp_q16(ur_w);
            ui = clamp_q16(ui_w);
            re_w = (prod(ur, yr) - prod(ui, yi)) >>> FIX_FRAC;
            im_w = (prod(ur, yi) + prod(ui, yr)) >>> FIX_FRAC;
            ysat = ysat | out_of_range(re_w) | out_of_range(im_w);
            yr = clamp_q16(re_w);
            yi = clamp_q16(im_w);
            // x saturating on its own does not end the orbit
            re_w = (prod(xr, xr) - prod(xi, xi)) >>> FIX_FRAC;
            im_w = (prod(xr, xi) + prod(xi, xr)) >>> FIX_FRAC;
            xr = clamp_q16(re_w);
            xi = clamp_q16(im_w);
            n++;
        end
        if (n < iter_limit)
        begin
            c.escaped = 1'b1;
            c.code = (yi > 0) ? CODE_W'(2 * n) : CODE_W'(2 * n + NONPOS_OFFSET);
        end
        else
        begin
            c.escaped = 1'b0;
            c.code = NO_ESCAPE_CODE;
        end
        return c;
    endfunction

    function automatic logic [31:0] rand_q();
        logic signed [31:0] r;
        int                 pick;
        r = $urandom;
        pick = $urandom_range(99);
        if (pick < 20)
            return r;
        if (pick < 70)
            return r >>> 2;
        return r >>> 4;
    endfunction

    // magnitude of at least 2.0, so a pure squaring orbit leaves fast
    function automatic logic [31:0] far_coord();
        logic [31:0] m;
        m = $urandom_range(32'h7FFF_FFFF, 32'h2000_0000);
        return ($urandom_range(1) != 0) ? m : -m;
    endfunction

    task automatic flag_error(input string what, input string exp_s, input string act_s);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %s, got %s at %0t", what, exp_s, act_s, $time);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            spet_pkg::REG_X_START_RE: x0_re = val;
            spet_pkg::REG_X_START_IM: x0_im = val;
            spet_pkg::REG_SHIFT_RE:   b_re = val;
            spet_pkg::REG_SHIFT_IM:   b_im = val;
            spet_pkg::REG_ITER_LIMIT: iter_limit = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] xre, input logic [31:0] xim,
                            input logic [31:0] bre, input logic [31:0] bim,
                            input logic [15:0] lim);
        write_reg(spet_pkg::REG_X_START_RE, xre);
        write_reg(spet_pkg::REG_X_START_IM, xim);
        write_reg(spet_pkg::REG_SHIFT_RE, bre);
        write_reg(spet_pkg::REG_SHIFT_IM, bim);
        write_reg(spet_pkg::REG_ITER_LIMIT, {16'd0, lim});
    endtask

    task automatic add_point(input logic [31:0] re, input logic [31:0] im, input bit drain);
        point_t p;
        p.re = re;
        p.im = im;
        p.drain = drain;
        pending_points.push_back(p);
    endtask

    task automatic wait_idle();
        while (pending_points.size() != 0 || s_tvalid || due_colors.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_mode(input int mode);
        send_idle_pct = send_idle_tab[mode];
        recv_stall_pct = recv_stall_tab[mode];
    endtask

    // driver: one item at a time from the pending queue
    always @(negedge clk)
    begin
        if (!s_tvalid || point_taken)
        begin
            point_taken = 1'b0;
            if (pending_points.size() != 0
                && !(pending_points[0].drain && due_colors.size() != 0)
                && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_points[0].im, pending_points[0].re};
                void'(pending_points.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: result check first, then predict the item taken at this edge
    always @(posedge clk)
    begin : monitor
        color_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_colors.size() == 0)
                begin
                    flag_error("result item", "none",
                               $sformatf("%0d", $signed(m_tdata[CODE_W-1:0])));
                end
                else
                begin
                    want = due_colors.pop_front();
                    if (m_tdata[CODE_W-1:0] !== want.code)
                        flag_error("color_code", $sformatf("%0d", $signed(want.code)),
                                   $sformatf("%0d", $signed(m_tdata[CODE_W-1:0])));
                    if (m_tuser !== want.escaped)
                        flag_error("escaped", $sformatf("%0b", want.escaped),
                                   $sformatf("%0b", m_tuser));
                    if (m_tdata[spet_pkg::OUT_TDATA_W-1:CODE_W] !== '0)
                        flag_error("tdata pad", "0",
                                   $sformatf("%0h", m_tdata[spet_pkg::OUT_TDATA_W-1:CODE_W]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                due_colors.push_back(escape_color(s_tdata[31:0], s_tdata[63:32]));
                point_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset registers: x0 = b = 1.0, limit 500
        set_mode(0);
        add_point(Q_ZERO, Q_ZERO, 1'b0);        // fixed point at the origin
        add_point(Q_MAX, Q_MAX, 1'b0);
        add_point(Q_MIN, Q_MIN, 1'b0);
        add_point(Q_MAX, Q_MIN, 1'b0);
        add_point(Q_MIN, Q_MAX, 1'b0);
        add_point(Q_MIN, Q_ZERO, 1'b0);         // real escape, im not positive
        add_point(Q_ZERO, Q_MAX, 1'b0);
        add_point(32'hF000_0000, Q_ZERO, 1'b0); // -1.0, bounded cycle
        add_point(32'h0400_0000, 32'h0400_0000, 1'b0);
        add_point(32'h0800_0000, 32'h1800_0000, 1'b0);
        wait_idle();

        // zero limit: nothing iterates
        set_regs(Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, 16'd0);
        add_point(Q_MAX, Q_MAX, 1'b0);
        add_point(Q_ZERO, Q_ZERO, 1'b0);
        wait_idle();

        // escape right after the first iteration
        set_regs(Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, 16'd2);
        add_point(Q_MAX, Q_MAX, 1'b0);
        add_point(Q_MIN, Q_MIN, 1'b0);
        add_point(Q_MAX, Q_MIN, 1'b0);
        wait_idle();

        // x blows up and drives u into saturation
        set_regs(Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, 16'd500);
        for (int k = spet_pkg::REG_ITER_LIMIT + 1; k < (1 << IDX_W); k++)
            write_reg(IDX_W'(k), $urandom);     // unmapped indexes change nothing
        add_point(Q_ZERO, Q_ZERO, 1'b0);
        add_point(32'h0199_999A, 32'h0199_999A, 1'b0);
        add_point(32'hFE66_6666, Q_MAX, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (phase_limit[ph] == 16'hFFFF)
                set_regs(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, phase_limit[ph]);
            else if (ph == 2)
                set_regs(Q_MIN, Q_MAX, Q_MAX, Q_MIN, phase_limit[ph]);
            else
                set_regs(rand_q(), rand_q(), rand_q(), rand_q(), phase_limit[ph]);
            set_mode(ph % 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase_limit[ph] == 16'hFFFF)
                    add_point(far_coord(), far_coord(), k == DRAIN_AT);
                else
                    add_point(rand_q(), rand_q(), k == DRAIN_AT);
            end
            wait_idle();
        end

        repeat (200) @(posedge clk);
        if (errors == 0 && due_colors.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/spet_pkg.sv
hw/rtl/spet_dp.sv
hw/rtl/spet_ctrl.sv
hw/rtl/skew_product_escape_time.sv
hw/rtl/spet_check.sv
sim/tb_skew_product_escape_time.sv
